/* design/wpl_pkg.sv */
// Package for the wireframe line expander: item types, fixed-point constants,
// the box edge list and the elaboration-time CORDIC used to build the cos/sin table.
// No dependencies.
package wpl_pkg;

	// Primitive kinds carried in the mode field.
	localparam logic [1:0] MODE_LINE = 2'd0;
	localparam logic [1:0] MODE_BOX  = 2'd1;
	localparam logic [1:0] MODE_SPH  = 2'd2;
	localparam logic [1:0] MODE_CAP  = 2'd3;

	// Fixed-point constants (Q2.30 unless noted).
	localparam longint HALF_PI_Q30     = 64'sd1686629713;
	localparam longint CORDIC_GAIN_Q30 = 64'sd652032874;
	localparam logic [31:0] NEAR_ONE_Q30 = 32'd1063004406;
	localparam logic [63:0] EPS_SQ_Q60 = 64'd1152921;
	localparam int CORDIC_STEPS = 30;

	localparam longint ATAN_Q30 [10] = '{
		64'sd843314857, 64'sd497837829, 64'sd263043837, 64'sd133525159, 64'sd67021687,
		64'sd33543516, 64'sd16775851, 64'sd8388437, 64'sd4194283, 64'sd2097149
	};

	// Box edges as pairs of corner codes (bit 2 selects +X, bit 1 +Y, bit 0 +Z).
	localparam logic [2:0] BOX_A [12] = '{3'd0, 3'd4, 3'd5, 3'd1, 3'd2, 3'd6,
		3'd7, 3'd3, 3'd0, 3'd4, 3'd5, 3'd1};
	localparam logic [2:0] BOX_B [12] = '{3'd4, 3'd5, 3'd1, 3'd0, 3'd6, 3'd7,
		3'd3, 3'd2, 3'd2, 3'd6, 3'd7, 3'd3};

	typedef struct packed {
		logic [1:0]         mode;
		logic signed [31:0] first_x;
		logic signed [31:0] first_y;
		logic signed [31:0] first_z;
		logic signed [31:0] second_x;
		logic signed [31:0] second_y;
		logic signed [31:0] second_z;
		logic [30:0]        radius;
		logic [31:0]        line_color;
	} in_t;

	typedef struct packed {
		logic signed [31:0] seg_start_x;
		logic signed [31:0] seg_start_y;
		logic signed [31:0] seg_start_z;
		logic signed [31:0] seg_end_x;
		logic signed [31:0] seg_end_y;
		logic signed [31:0] seg_end_z;
		logic [31:0]        seg_color;
		logic               last_segment;
	} out_t;

	// Cos and sin of 2*pi*i/n in Q2.30, packed as {cos, sin}. Only called with
	// constant arguments, so the whole loop is evaluated at elaboration.
	function automatic logic [63:0] cordic_cs(int n, int i);
		logic [35:0] num;
		longint unsigned rem;
		logic [35:0] q;
		logic [31:0] ph;
		longint x;
		longint y;
		longint z;
		longint a;
		longint dx;
		longint dy;
		longint c;
		longint s;
		num = 36'(i) << 32;
		rem = 0;
		q = '0;
		// Phase as a fraction of a full turn, by shift-and-subtract.
		for (int b = 35; b >= 0; b--) begin
			rem = (rem << 1) | longint'(num[b]);
			q = q << 1;
			if (rem >= longint'(n)) begin
				rem = rem - longint'(n);
				q[0] = 1'b1;
			end
		end
		ph = q[31:0];
		x = CORDIC_GAIN_Q30;
		y = 0;
		z = (longint'(ph[29:0]) * HALF_PI_Q30) >>> 30;
		for (int k = 0; k < CORDIC_STEPS; k++) begin
			a = (k < 10) ? ATAN_Q30[k] : (longint'(1) << (30 - k));
			dx = y >>> k;
			dy = x >>> k;
			if (z >= 0) begin
				x = x - dx;
				y = y + dy;
				z = z - a;
			end else begin
				x = x + dx;
				y = y - dy;
				z = z + a;
			end
		end
		case (ph[31:30])
			2'd0: begin
				c = x;
				s = y;
			end
			2'd1: begin
				c = -y;
				s = x;
			end
			2'd2: begin
				c = -x;
				s = -y;
			end
			default: begin
				c = y;
				s = -x;
			end
		endcase
		return {c[31:0], s[31:0]};
	endfunction

endpackage

/* design/wireframe_primitive_line_expander_unit.sv */
// Wireframe line expander top level: sequencer, shared multiplier, square-root
// and divider steps, and the output register. Depends on wpl_pkg.
//
// One request is taken while the block is idle and expanded into line segments
// that leave one at a time through a registered output: a line gives 1 segment,
// an axis box 12, a sphere 3*CIRCLE_SEGMENTS and a capsule 2*CIRCLE_SEGMENTS+4.
// All products go through a single 34x32 multiplier with a registered product, and
// a circle point takes six products and the emit step. A capsule first does two
// vector normalizations, each a bit-at-a-time shift to full scale, a 32-step
// square root and three 32-step divisions, then the basis products, then two
// circles and 4 sides. Segments stall while the output is not taken.
module wireframe_primitive_line_expander_unit #(
	parameter int CIRCLE_SEGMENTS = 12,
	parameter int FRAC_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  wpl_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output wpl_pkg::out_t out_data
);
	import wpl_pkg::*;

	localparam int NV_W = 63 - FRAC_BITS;
	localparam int TW = $clog2(CIRCLE_SEGMENTS);
	localparam int IW = $clog2(CIRCLE_SEGMENTS + 1);
	localparam logic [IW-1:0] I_LAST = IW'(CIRCLE_SEGMENTS);

	localparam logic [4:0] ST_IDLE  = 5'd0;
	localparam logic [4:0] ST_LINE  = 5'd1;
	localparam logic [4:0] ST_BOX   = 5'd2;
	localparam logic [4:0] ST_SSET  = 5'd3;
	localparam logic [4:0] ST_CIR   = 5'd4;
	localparam logic [4:0] ST_CPT   = 5'd5;
	localparam logic [4:0] ST_SIDE  = 5'd6;
	localparam logic [4:0] ST_CAP0  = 5'd7;
	localparam logic [4:0] ST_NABS  = 5'd8;
	localparam logic [4:0] ST_NTINY = 5'd9;
	localparam logic [4:0] ST_NSHF  = 5'd10;
	localparam logic [4:0] ST_NLEN  = 5'd11;
	localparam logic [4:0] ST_NSQ   = 5'd12;
	localparam logic [4:0] ST_NDIVI = 5'd13;
	localparam logic [4:0] ST_NDIV  = 5'd14;
	localparam logic [4:0] ST_NDONE = 5'd15;
	localparam logic [4:0] ST_PB    = 5'd16;
	localparam logic [4:0] ST_UV    = 5'd17;

	// Control state.
	logic [4:0]    state_q;
	logic [5:0]    cnt_q;
	logic [1:0]    j_q;
	logic          t_q;
	logic          ph_q;
	logic [IW-1:0] i_q;
	logic [1:0]    circ_q;
	logic          nsel_q;
	logic          out_valid_q;

	// Datapath registers.
	in_t                   in_q;
	out_t                  out_q;
	logic signed [65:0]    prod_q;
	logic signed [35:0]    acc_q;
	logic signed [33:0]    c_q [3];
	logic signed [33:0]    u_q [3];
	logic signed [33:0]    v_q [3];
	logic signed [35:0]    pt_q [3];
	logic signed [35:0]    prev_q [3];
	logic signed [NV_W-1:0] nv_q [3];
	logic [NV_W-1:0]       m_q [3];
	logic [2:0]            sg_q;
	logic [63:0]           len2_q;
	logic [63:0]           x_q;
	logic [63:0]           res_q;
	logic [31:0]           len_q;
	logic [61:0]           num_q;
	logic [32:0]           rem_q;
	logic [31:0]           quo_q;
	logic signed [31:0]    n_q [3];
	logic signed [31:0]    pa_q [3];
	logic signed [33:0]    pb_q [3];

	// Cos/sin table built at elaboration.
	logic [63:0] trig_w [CIRCLE_SEGMENTS];
	for (genvar gi = 0; gi < CIRCLE_SEGMENTS; gi++) begin : g_trig
		localparam logic [63:0] CS = cordic_cs(CIRCLE_SEGMENTS, gi);
		assign trig_w[gi] = CS;
	end

	// Saturate a wide coordinate to 32 bits.
	function automatic logic signed [31:0] sat32(logic signed [35:0] v);
		if (v[35:31] != {5{v[31]}}) begin
			return v[35] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end
		return v[31:0];
	endfunction

	// Request operands and derived points.
	logic signed [35:0] fv [3];
	logic signed [35:0] sv [3];
	logic signed [35:0] topv [3];
	logic signed [35:0] botv [3];
	always_comb begin
		fv[0] = 36'(in_q.first_x);
		fv[1] = 36'(in_q.first_y);
		fv[2] = 36'(in_q.first_z);
		sv[0] = 36'(in_q.second_x);
		sv[1] = 36'(in_q.second_y);
		sv[2] = 36'(in_q.second_z);
		for (int k = 0; k < 3; k++) begin
			topv[k] = fv[k] + sv[k];
			botv[k] = fv[k] - sv[k];
		end
	end

	// Table lookup for the current circle point; the closing point reuses index 0.
	logic [TW-1:0]      idx;
	logic signed [31:0] cosv;
	logic signed [31:0] sinv;
	always_comb begin
		idx = (i_q == I_LAST) ? '0 : i_q[TW-1:0];
		cosv = trig_w[idx][63:32];
		sinv = trig_w[idx][31:0];
	end

	// Operand selection for the shared multiplier.
	logic signed [33:0] mul_a;
	logic signed [31:0] mul_b;
	logic [1:0]         j1;
	logic [1:0]         j2;
	logic [1:0]         uvk;
	always_comb begin
		j1 = (j_q == 2'd2) ? 2'd0 : j_q + 2'd1;
		j2 = (j_q == 2'd0) ? 2'd2 : j_q - 2'd1;
		uvk = (cnt_q < 6'd3) ? cnt_q[1:0] : 2'(cnt_q - 6'd3);
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_CIR: begin
				mul_a = t_q ? v_q[j_q] : u_q[j_q];
				mul_b = t_q ? sinv : cosv;
			end
			ST_NTINY, ST_NLEN: begin
				mul_a = {2'b00, m_q[j_q][31:0]};
				mul_b = m_q[j_q][31:0];
			end
			ST_PB: begin
				mul_a = 34'(t_q ? n_q[j2] : n_q[j1]);
				mul_b = t_q ? pa_q[j1] : pa_q[j2];
			end
			ST_UV: begin
				mul_a = (cnt_q < 6'd3) ? 34'(pa_q[uvk]) : pb_q[uvk];
				mul_b = {1'b0, in_q.radius};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Rounded Q30 product and running sum of squares.
	logic signed [65:0] rsum;
	logic signed [35:0] rnd;
	logic [63:0]        len2_sum;
	logic               tiny_ok;
	always_comb begin
		rsum = prod_q + 66'sd536870912;
		rnd = rsum[65:30];
		len2_sum = ((j_q == 2'd0) ? 64'd0 : len2_q) + prod_q[63:0];
		tiny_ok = (len2_sum <= EPS_SQ_Q60);
	end

	// Magnitude range tests for normalization.
	logic [NV_W-1:0] mor;
	logic            m_big;
	logic            m_low;
	logic            m_tiny;
	always_comb begin
		mor = m_q[0] | m_q[1] | m_q[2];
		m_big = |mor[NV_W-1:31];
		m_low = !m_big && !mor[30];
		m_tiny = (mor[NV_W-1:21] == '0);
	end

	// One step of the integer square root.
	logic [63:0] bitv;
	logic [63:0] sq_sum;
	logic        sq_ge;
	logic [63:0] x_next;
	logic [63:0] res_next;
	always_comb begin
		bitv = 64'h4000_0000_0000_0000 >> {cnt_q[4:0], 1'b0};
		sq_sum = res_q + bitv;
		sq_ge = (x_q >= sq_sum);
		x_next = sq_ge ? x_q - sq_sum : x_q;
		res_next = sq_ge ? (res_q >> 1) + bitv : res_q >> 1;
	end

	// One step of the restoring divider and its start values.
	logic [32:0] trial;
	logic        dv_ge;
	logic [32:0] rem_next;
	logic [31:0] quo_next;
	logic [61:0] num_init;
	always_comb begin
		trial = {rem_q[31:0], num_q[5'd31 - cnt_q[4:0]]};
		dv_ge = (trial >= {1'b0, len_q});
		rem_next = dv_ge ? trial - {1'b0, len_q} : trial;
		quo_next = {quo_q[30:0], dv_ge};
		num_init = {1'b0, m_q[j_q][30:0], 30'b0} + {31'b0, len_q[31:1]};
	end

	// Basis helper choice.
	logic [31:0] ny_abs;
	always_comb begin
		ny_abs = nv_q[1][NV_W-1] ? 32'(-nv_q[1]) : 32'(nv_q[1]);
	end

	// Segment selection for the output register.
	logic               slot_free;
	logic               emit;
	logic               seg_last;
	logic signed [35:0] seg_a [3];
	logic signed [35:0] seg_b [3];
	logic signed [35:0] dside;
	always_comb begin
		slot_free = !out_valid_q || out_ready;
		emit = 1'b0;
		seg_last = 1'b0;
		dside = '0;
		for (int k = 0; k < 3; k++) begin
			seg_a[k] = prev_q[k];
			seg_b[k] = pt_q[k];
		end
		case (state_q)
			ST_LINE: begin
				emit = slot_free;
				seg_last = 1'b1;
				for (int k = 0; k < 3; k++) begin
					seg_a[k] = fv[k];
					seg_b[k] = sv[k];
				end
			end
			ST_BOX: begin
				emit = slot_free;
				seg_last = (cnt_q == 6'd11);
				for (int k = 0; k < 3; k++) begin
					seg_a[k] = BOX_A[cnt_q[3:0]][2 - k] ? topv[k] : botv[k];
					seg_b[k] = BOX_B[cnt_q[3:0]][2 - k] ? topv[k] : botv[k];
				end
			end
			ST_CPT: begin
				emit = slot_free && (i_q != '0);
				seg_last = (in_q.mode == MODE_SPH) && (circ_q == 2'd2) && (i_q == I_LAST);
			end
			ST_SIDE: begin
				emit = slot_free;
				seg_last = (cnt_q == 6'd3);
				for (int k = 0; k < 3; k++) begin
					dside = (cnt_q < 6'd2) ? 36'(u_q[k]) : 36'(v_q[k]);
					if (cnt_q[0]) begin
						dside = -dside;
					end
					seg_a[k] = botv[k] + dside;
					seg_b[k] = topv[k] + dside;
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			j_q <= '0;
			t_q <= 1'b0;
			ph_q <= 1'b0;
			i_q <= '0;
			circ_q <= '0;
			nsel_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						cnt_q <= '0;
						circ_q <= '0;
						case (in_data.mode)
							MODE_LINE: state_q <= ST_LINE;
							MODE_BOX:  state_q <= ST_BOX;
							MODE_SPH:  state_q <= ST_SSET;
							default:   state_q <= ST_CAP0;
						endcase
					end
				end
				ST_LINE: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_BOX: begin
					if (slot_free) begin
						if (cnt_q == 6'd11) begin
							state_q <= ST_IDLE;
						end else begin
							cnt_q <= cnt_q + 6'd1;
						end
					end
				end
				ST_SSET: begin
					i_q <= '0;
					state_q <= ST_CIR;
				end
				ST_CIR: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						t_q <= !t_q;
						if (t_q) begin
							if (j_q == 2'd2) begin
								j_q <= '0;
								state_q <= ST_CPT;
							end else begin
								j_q <= j_q + 2'd1;
							end
						end
					end
				end
				ST_CPT: begin
					if (i_q == '0) begin
						i_q <= i_q + 1'b1;
						state_q <= ST_CIR;
					end else if (slot_free) begin
						if (i_q == I_LAST) begin
							i_q <= '0;
							if (in_q.mode == MODE_SPH) begin
								if (circ_q == 2'd2) begin
									state_q <= ST_IDLE;
								end else begin
									circ_q <= circ_q + 2'd1;
									state_q <= ST_SSET;
								end
							end else if (circ_q == 2'd0) begin
								circ_q <= 2'd1;
								state_q <= ST_CIR;
							end else begin
								cnt_q <= '0;
								state_q <= ST_SIDE;
							end
						end else begin
							i_q <= i_q + 1'b1;
							state_q <= ST_CIR;
						end
					end
				end
				ST_SIDE: begin
					if (slot_free) begin
						if (cnt_q == 6'd3) begin
							state_q <= ST_IDLE;
						end else begin
							cnt_q <= cnt_q + 6'd1;
						end
					end
				end
				ST_CAP0: begin
					nsel_q <= 1'b0;
					state_q <= ST_NABS;
				end
				ST_NABS: begin
					j_q <= '0;
					state_q <= m_tiny ? ST_NTINY : ST_NSHF;
				end
				ST_NTINY: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						if (j_q == 2'd2) begin
							j_q <= '0;
							state_q <= tiny_ok ? ST_NDONE : ST_NSHF;
						end else begin
							j_q <= j_q + 2'd1;
						end
					end
				end
				ST_NSHF: begin
					if (!m_big && !m_low) begin
						j_q <= '0;
						state_q <= ST_NLEN;
					end
				end
				ST_NLEN: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						if (j_q == 2'd2) begin
							j_q <= '0;
							cnt_q <= '0;
							state_q <= ST_NSQ;
						end else begin
							j_q <= j_q + 2'd1;
						end
					end
				end
				ST_NSQ: begin
					if (cnt_q == 6'd31) begin
						cnt_q <= '0;
						state_q <= ST_NDIVI;
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				ST_NDIVI: begin
					cnt_q <= '0;
					state_q <= ST_NDIV;
				end
				ST_NDIV: begin
					if (cnt_q == 6'd31) begin
						cnt_q <= '0;
						if (j_q == 2'd2) begin
							j_q <= '0;
							state_q <= ST_NDONE;
						end else begin
							j_q <= j_q + 2'd1;
							state_q <= ST_NDIVI;
						end
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				ST_NDONE: begin
					if (!nsel_q) begin
						nsel_q <= 1'b1;
						state_q <= ST_NABS;
					end else begin
						j_q <= '0;
						state_q <= ST_PB;
					end
				end
				ST_PB: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						t_q <= !t_q;
						if (t_q) begin
							if (j_q == 2'd2) begin
								j_q <= '0;
								cnt_q <= '0;
								state_q <= ST_UV;
							end else begin
								j_q <= j_q + 2'd1;
							end
						end
					end
				end
				ST_UV: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						if (cnt_q == 6'd5) begin
							cnt_q <= '0;
							i_q <= '0;
							circ_q <= '0;
							state_q <= ST_CIR;
						end else begin
							cnt_q <= cnt_q + 6'd1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (emit) begin
			out_q.seg_start_x <= sat32(seg_a[0]);
			out_q.seg_start_y <= sat32(seg_a[1]);
			out_q.seg_start_z <= sat32(seg_a[2]);
			out_q.seg_end_x <= sat32(seg_b[0]);
			out_q.seg_end_y <= sat32(seg_b[1]);
			out_q.seg_end_z <= sat32(seg_b[2]);
			out_q.seg_color <= in_q.line_color;
			out_q.last_segment <= seg_last;
		end
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					in_q <= in_data;
				end
			end
			ST_SSET: begin
				for (int k = 0; k < 3; k++) begin
					c_q[k] <= fv[k][33:0];
					u_q[k] <= '0;
					v_q[k] <= '0;
				end
				case (circ_q)
					2'd0: begin
						u_q[0] <= 34'(in_q.radius);
						v_q[1] <= 34'(in_q.radius);
					end
					2'd1: begin
						u_q[1] <= 34'(in_q.radius);
						v_q[2] <= 34'(in_q.radius);
					end
					default: begin
						u_q[2] <= 34'(in_q.radius);
						v_q[0] <= 34'(in_q.radius);
					end
				endcase
			end
			ST_CIR: begin
				if (!ph_q) begin
					if (!t_q) begin
						acc_q <= 36'(c_q[j_q]);
					end
				end else if (!t_q) begin
					acc_q <= acc_q + rnd;
				end else begin
					pt_q[j_q] <= acc_q + rnd;
				end
			end
			ST_CPT: begin
				if (i_q == '0 || slot_free) begin
					prev_q <= pt_q;
				end
				if (slot_free && i_q == I_LAST && circ_q == 2'd0) begin
					for (int k = 0; k < 3; k++) begin
						c_q[k] <= botv[k][33:0];
					end
				end
			end
			ST_CAP0: begin
				nv_q[0] <= NV_W'(in_q.second_x) <<< (30 - FRAC_BITS);
				nv_q[1] <= NV_W'(in_q.second_y) <<< (30 - FRAC_BITS);
				nv_q[2] <= NV_W'(in_q.second_z) <<< (30 - FRAC_BITS);
			end
			ST_NABS: begin
				for (int k = 0; k < 3; k++) begin
					sg_q[k] <= nv_q[k][NV_W-1];
					m_q[k] <= nv_q[k][NV_W-1] ? NV_W'(-nv_q[k]) : NV_W'(nv_q[k]);
				end
			end
			ST_NTINY: begin
				if (ph_q) begin
					len2_q <= len2_sum;
				end
			end
			ST_NSHF: begin
				for (int k = 0; k < 3; k++) begin
					if (m_big) begin
						m_q[k] <= m_q[k] >> 1;
					end else if (m_low) begin
						m_q[k] <= m_q[k] << 1;
					end
				end
			end
			ST_NLEN: begin
				if (ph_q) begin
					len2_q <= len2_sum;
					if (j_q == 2'd2) begin
						x_q <= len2_sum;
						res_q <= '0;
					end
				end
			end
			ST_NSQ: begin
				x_q <= x_next;
				res_q <= res_next;
				if (cnt_q == 6'd31) begin
					len_q <= res_next[31:0];
				end
			end
			ST_NDIVI: begin
				num_q <= num_init;
				rem_q <= {3'b000, num_init[61:32]};
				quo_q <= '0;
			end
			ST_NDIV: begin
				rem_q <= rem_next;
				quo_q <= quo_next;
				if (cnt_q == 6'd31) begin
					nv_q[j_q] <= sg_q[j_q] ? -NV_W'(quo_next) : NV_W'(quo_next);
				end
			end
			ST_NDONE: begin
				if (!nsel_q) begin
					for (int k = 0; k < 3; k++) begin
						n_q[k] <= nv_q[k][31:0];
					end
					if (ny_abs < NEAR_ONE_Q30) begin
						nv_q[0] <= nv_q[2];
						nv_q[1] <= '0;
						nv_q[2] <= -nv_q[0];
					end else begin
						nv_q[0] <= '0;
						nv_q[1] <= -nv_q[2];
						nv_q[2] <= nv_q[1];
					end
				end else begin
					for (int k = 0; k < 3; k++) begin
						pa_q[k] <= nv_q[k][31:0];
					end
				end
			end
			ST_PB: begin
				if (ph_q) begin
					if (!t_q) begin
						acc_q <= rnd;
					end else begin
						pb_q[j_q] <= 34'(acc_q - rnd);
					end
				end
			end
			ST_UV: begin
				if (ph_q) begin
					if (cnt_q < 6'd3) begin
						u_q[uvk] <= rnd[33:0];
					end else begin
						v_q[uvk] <= rnd[33:0];
					end
					if (cnt_q == 6'd5) begin
						for (int k = 0; k < 3; k++) begin
							c_q[k] <= topv[k][33:0];
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	// Checks on the sequencer.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("block still ready after taking an item");

	a_box_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BOX) |-> (cnt_q < 6'd12))
		else $error("box edge counter out of range");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && seg_last) |=> (state_q == ST_IDLE))
		else $error("sequencer kept working after the final segment");

	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_NDIV) |-> (len_q[31:30] != 2'b00))
		else $error("divisor below full scale during normalization");

	a_point_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CIR) |-> (i_q <= I_LAST))
		else $error("circle point index out of range");

endmodule

/* dv/wireframe_primitive_line_expander_unit_tb.sv */
// Testbench for the wireframe line expander: a directed table and random requests,
// checked segment by segment against a fixed-point predictor written here.
// Depends on wpl_pkg and wireframe_primitive_line_expander_unit.
module wireframe_primitive_line_expander_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import wpl_pkg::*;

	localparam int NSEG = 12;
	localparam int FBITS = 16;
	localparam int RANDOM_ITEMS = 395;
	localparam int STALL_LIMIT = 20000;

	typedef longint vec3_t [3];

	typedef struct packed {
		in_t  req;
		logic typed;
		out_t seg;
	} row_t;

	// Directed requests. Line rows carry their segment typed in; the rest use the predictor.
	localparam int NROWS = 17;
	localparam row_t ROWS [NROWS] = '{
		'{'{MODE_LINE, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 31'd0, 32'd0}, 1'b1,
			'{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1}},
		'{'{MODE_LINE, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
			32'h7fffffff, 32'h80000000, 31'h7fffffff, 32'hffffffff}, 1'b1,
			'{32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
			32'h80000000, 32'hffffffff, 1'b1}},
		'{'{MODE_LINE, 32'h00010000, 32'hffff0000, 32'h12345678, 32'h87654321,
			32'h00000001, 32'hffffffff, 31'd5, 32'h11223344}, 1'b1,
			'{32'h00010000, 32'hffff0000, 32'h12345678, 32'h87654321, 32'h00000001,
			32'hffffffff, 32'h11223344, 1'b1}},
		'{'{MODE_BOX, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 31'd0, 32'h0}, 1'b0, '0},
		'{'{MODE_BOX, 32'h00010000, 32'h00020000, 32'hfffd0000, 32'h00008000,
			32'h00010000, 32'h00018000, 31'd0, 32'hff0000ff}, 1'b0, '0},
		'{'{MODE_BOX, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
			32'h7fffffff, 32'h80000000, 31'd0, 32'h00ff00ff}, 1'b0, '0},
		'{'{MODE_BOX, 32'd0, 32'd0, 32'd0, 32'hfffe0000, 32'hffff0000, 32'hffff8000,
			31'd0, 32'h12345678}, 1'b0, '0},
		'{'{MODE_SPH, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 31'd0, 32'h1}, 1'b0, '0},
		'{'{MODE_SPH, 32'h00010000, 32'hffff0000, 32'h00020000, 32'd0, 32'd0, 32'd0,
			31'h00030000, 32'h2}, 1'b0, '0},
		'{'{MODE_SPH, 32'h7fffffff, 32'h80000000, 32'd0, 32'hffffffff, 32'hffffffff,
			32'hffffffff, 31'h7fffffff, 32'h3}, 1'b0, '0},
		'{'{MODE_CAP, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 31'h00010000, 32'h4},
			1'b0, '0},
		'{'{MODE_CAP, 32'd0, 32'd0, 32'd0, 32'd0, 32'h00020000, 32'd0, 31'h00010000,
			32'h5}, 1'b0, '0},
		'{'{MODE_CAP, 32'h00010000, 32'd0, 32'd0, 32'd0, 32'hfffe0000, 32'd0,
			31'h00020000, 32'h6}, 1'b0, '0},
		'{'{MODE_CAP, 32'd0, 32'd0, 32'd0, 32'h00000001, 32'd0, 32'd0, 31'h00010000,
			32'h7}, 1'b0, '0},
		'{'{MODE_CAP, 32'd0, 32'd0, 32'd0, 32'h00000030, 32'h00000020, 32'h00000010,
			31'h00010000, 32'h8}, 1'b0, '0},
		'{'{MODE_CAP, 32'h7fffffff, 32'h80000000, 32'h00001000, 32'h7fffffff,
			32'h80000000, 32'h7fffffff, 31'h7fffffff, 32'h9}, 1'b0, '0},
		'{'{MODE_CAP, 32'd0, 32'd0, 32'd0, 32'h00030000, 32'h00010000, 32'hfffe0000,
			31'h00028000, 32'ha}, 1'b0, '0}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_t out_data;

	out_t expected_segs [$];
	longint cos_tab [NSEG];
	longint sin_tab [NSEG];
	int errors = 0;
	int stall_cycles = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	wireframe_primitive_line_expander_unit #(
		.CIRCLE_SEGMENTS(NSEG),
		.FRAC_BITS(FBITS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Product with a Q2.30 factor, rounded to nearest.
	function automatic longint mul_q30(longint a, longint b);
		return (a * b + (longint'(1) << 29)) >>> 30;
	endfunction

	function automatic logic signed [31:0] clamp32(longint v);
		if (v > 64'sd2147483647)
			return 32'h7fffffff;
		if (v < -64'sd2147483648)
			return 32'h80000000;
		return v[31:0];
	endfunction

	function automatic longint unsigned floor_sqrt(longint unsigned x);
		longint unsigned res;
		longint unsigned bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > x)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (x >= res + bitv) begin
				x = x - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	// Builds the cos/sin table by CORDIC on the quarter-turn remainder.
	task automatic build_trig_table();
		logic [31:0] ph;
		longint x;
		longint y;
		longint z;
		longint a;
		longint dx;
		longint dy;
		for (int i = 0; i < NSEG; i++) begin
			ph = 32'((64'(i) << 32) / NSEG);
			x = CORDIC_GAIN_Q30;
			y = 0;
			z = longint'((64'(ph[29:0]) * 64'(HALF_PI_Q30)) >> 30);
			for (int k = 0; k < 30; k++) begin
				a = (k < 10) ? ATAN_Q30[k] : (longint'(1) << (30 - k));
				dx = y >>> k;
				dy = x >>> k;
				if (z >= 0) begin
					x = x - dx;
					y = y + dy;
					z = z - a;
				end else begin
					x = x + dx;
					y = y - dy;
					z = z + a;
				end
			end
			case (ph[31:30])
				2'd0: begin
					cos_tab[i] = x;
					sin_tab[i] = y;
				end
				2'd1: begin
					cos_tab[i] = -y;
					sin_tab[i] = x;
				end
				2'd2: begin
					cos_tab[i] = -x;
					sin_tab[i] = -y;
				end
				default: begin
					cos_tab[i] = y;
					sin_tab[i] = -x;
				end
			endcase
		end
	endtask

	// Unit vector in Q2.30; a vector below the epsilon length is returned unchanged.
	function automatic vec3_t unit_vec(vec3_t v);
		longint unsigned m [3];
		longint unsigned maxm;
		longint unsigned len2;
		longint unsigned len;
		longint q;
		vec3_t r;
		maxm = 0;
		r = v;
		for (int j = 0; j < 3; j++) begin
			m[j] = (v[j] < 0) ? 64'(-v[j]) : 64'(v[j]);
			if (m[j] > maxm)
				maxm = m[j];
		end
		if (maxm < (64'd1 << 21)) begin
			len2 = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
			if (len2 <= EPS_SQ_Q60)
				return r;
		end
		while (maxm >= (64'd1 << 31)) begin
			maxm = maxm >> 1;
			for (int j = 0; j < 3; j++)
				m[j] = m[j] >> 1;
		end
		while (maxm < (64'd1 << 30)) begin
			maxm = maxm << 1;
			for (int j = 0; j < 3; j++)
				m[j] = m[j] << 1;
		end
		len2 = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
		len = floor_sqrt(len2);
		for (int j = 0; j < 3; j++) begin
			q = longint'(((m[j] << 30) + len / 2) / len);
			r[j] = (v[j] < 0) ? -q : q;
		end
		return r;
	endfunction

	function automatic vec3_t cross_q30(vec3_t a, vec3_t b);
		vec3_t r;
		r[0] = mul_q30(a[1], b[2]) - mul_q30(a[2], b[1]);
		r[1] = mul_q30(a[2], b[0]) - mul_q30(a[0], b[2]);
		r[2] = mul_q30(a[0], b[1]) - mul_q30(a[1], b[0]);
		return r;
	endfunction

	task automatic push_segment(vec3_t a, vec3_t b, logic [31:0] color);
		out_t s;
		s.seg_start_x = clamp32(a[0]);
		s.seg_start_y = clamp32(a[1]);
		s.seg_start_z = clamp32(a[2]);
		s.seg_end_x = clamp32(b[0]);
		s.seg_end_y = clamp32(b[1]);
		s.seg_end_z = clamp32(b[2]);
		s.seg_color = color;
		s.last_segment = 1'b0;
		expected_segs.insert(expected_segs.size(), s);
	endtask

	task automatic push_circle(vec3_t c, vec3_t u, vec3_t v, logic [31:0] color);
		vec3_t prev;
		vec3_t pt;
		int idx;
		for (int i = 0; i <= NSEG; i++) begin
			idx = (i == NSEG) ? 0 : i;
			for (int j = 0; j < 3; j++)
				pt[j] = c[j] + mul_q30(u[j], cos_tab[idx]) + mul_q30(v[j], sin_tab[idx]);
			if (i > 0)
				push_segment(prev, pt, color);
			prev = pt;
		end
	endtask

	// Expands one request into its expected segments.
	task automatic predict_segments(in_t q);
		vec3_t f;
		vec3_t s;
		vec3_t ca;
		vec3_t cb;
		vec3_t rx;
		vec3_t ry;
		vec3_t rz;
		vec3_t top;
		vec3_t bot;
		vec3_t n;
		vec3_t helper;
		vec3_t pa;
		vec3_t pb;
		vec3_t ua;
		vec3_t ub;
		vec3_t p0;
		vec3_t p1;
		longint r;
		longint ny;
		longint d;
		r = longint'(q.radius);
		f = '{longint'(q.first_x), longint'(q.first_y), longint'(q.first_z)};
		s = '{longint'(q.second_x), longint'(q.second_y), longint'(q.second_z)};
		case (q.mode)
			MODE_LINE: push_segment(f, s, q.line_color);
			MODE_BOX: begin
				for (int i = 0; i < 12; i++) begin
					for (int j = 0; j < 3; j++) begin
						ca[j] = BOX_A[i][2 - j] ? f[j] + s[j] : f[j] - s[j];
						cb[j] = BOX_B[i][2 - j] ? f[j] + s[j] : f[j] - s[j];
					end
					push_segment(ca, cb, q.line_color);
				end
			end
			MODE_SPH: begin
				rx = '{r, 0, 0};
				ry = '{0, r, 0};
				rz = '{0, 0, r};
				push_circle(f, rx, ry, q.line_color);
				push_circle(f, ry, rz, q.line_color);
				push_circle(f, rz, rx, q.line_color);
			end
			default: begin
				for (int j = 0; j < 3; j++) begin
					top[j] = f[j] + s[j];
					bot[j] = f[j] - s[j];
					n[j] = s[j] * (longint'(1) << (30 - FBITS));
				end
				n = unit_vec(n);
				ny = (n[1] < 0) ? -n[1] : n[1];
				// Helper is +Y unless the axis is nearly along Y.
				if (ny < longint'(NEAR_ONE_Q30))
					helper = '{0, longint'(1) << 30, 0};
				else
					helper = '{longint'(1) << 30, 0, 0};
				pa = unit_vec(cross_q30(helper, n));
				pb = cross_q30(n, pa);
				for (int j = 0; j < 3; j++) begin
					ua[j] = mul_q30(pa[j], r);
					ub[j] = mul_q30(pb[j], r);
				end
				push_circle(top, ua, ub, q.line_color);
				push_circle(bot, ua, ub, q.line_color);
				for (int i = 0; i < 4; i++) begin
					for (int j = 0; j < 3; j++) begin
						d = (i < 2) ? ua[j] : ub[j];
						if (i & 1)
							d = -d;
						p0[j] = bot[j] + d;
						p1[j] = top[j] + d;
					end
					push_segment(p0, p1, q.line_color);
				end
			end
		endcase
		expected_segs[expected_segs.size() - 1].last_segment = 1'b1;
	endtask

	// Coordinates: mostly modest values, sometimes full range or an extreme.
	function automatic logic [31:0] rand_coord();
		case ($urandom_range(9))
			0: return $urandom();
			1: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
			2: return 32'($signed($urandom_range(64)) - 32);
			default: return 32'($signed($urandom_range(32'h00200000)) - 32'sh00100000);
		endcase
	endfunction

	function automatic in_t rand_request();
		in_t q;
		int pick;
		pick = $urandom_range(99);
		q.mode = (pick < 30) ? MODE_LINE : (pick < 55) ? MODE_BOX :
			(pick < 80) ? MODE_SPH : MODE_CAP;
		q.first_x = rand_coord();
		q.first_y = rand_coord();
		q.first_z = rand_coord();
		q.second_x = rand_coord();
		q.second_y = rand_coord();
		q.second_z = rand_coord();
		// Capsules sometimes get a zero or near-Y axis.
		if (q.mode == MODE_CAP && $urandom_range(7) == 0) begin
			q.second_x = $urandom_range(3);
			q.second_z = $urandom_range(3);
		end
		q.radius = ($urandom_range(4) == 0) ? 31'($urandom()) : 31'($urandom_range(32'h00080000));
		q.line_color = $urandom();
		return q;
	endfunction

	// Hands one item to the block and waits for it to be taken.
	task automatic send_request(in_t q, logic typed, out_t seg);
		in_valid <= 1'b1;
		in_data <= q;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (typed)
			expected_segs.insert(expected_segs.size(), seg);
		else
			predict_segments(q);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	// Output side: check each taken segment and pick the next ready value.
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			if (expected_segs.size() == 0) begin
				$display("%0t: unexpected segment %h", $realtime, out_data);
				errors <= errors + 1;
			end else begin
				if (out_data !== expected_segs[0]) begin
					$display("%0t: segment mismatch expected %h actual %h",
						$realtime, expected_segs[0], out_data);
					errors <= errors + 1;
				end
				void'(expected_segs.pop_front());
			end
		end
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Watchdog on cycles where neither channel moves an item.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		int total;
		build_trig_table();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < NROWS; i++)
			send_request(ROWS[i].req, ROWS[i].typed, ROWS[i].seg);
		total = RANDOM_ITEMS;
		for (int i = 0; i < total; i++) begin
			// Four idling phases: none, sender, receiver, both.
			case ((i * 4) / total)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 71;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 71;
				end
				default: begin
					send_idle_pct = 31;
					recv_stall_pct = 31;
				end
			endcase
			send_request(rand_request(), 1'b0, '0);
		end
		in_valid <= 1'b0;
		while (expected_segs.size() != 0)
			@(posedge clk);
		repeat (1000) @(posedge clk);
		if (errors == 0 && expected_segs.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
